[rtl/rps_pkg.sv]
// ----------------------------------------------------------------------------
// Route pattern segmenter package
// Field widths, result record, queue push record and default constants that
// the segmenter top level and its result queue share.
// ----------------------------------------------------------------------------
package rps_pkg;

   // Default largest pattern length in bytes.
   localparam int MAX_URI_BYTES_DEFAULT = 8192;

   // Configuration register width and reset value.
   localparam int            CFG_W            = 14;
   localparam logic [13:0]   MAX_LENGTH_RESET = 14'd8192;

   // Output field widths.
   localparam int TYPE_W    = 2;
   localparam int OFF_W     = 13;
   localparam int LEN_W     = 14;
   localparam int NLEN_W    = 13;
   localparam int STATUS_W  = 2;
   localparam int ERROFF_W  = 14;

   // Depth of the result queue (power of two).
   localparam int QUEUE_DEPTH = 4;

   // One result item.
   typedef struct packed {
      logic                  result_kind;
      logic [TYPE_W-1:0]     segment_type;
      logic [OFF_W-1:0]      segment_offset;
      logic [LEN_W-1:0]      segment_length;
      logic [OFF_W-1:0]      name_offset;
      logic [NLEN_W-1:0]     name_length;
      logic [STATUS_W-1:0]   status;
      logic [ERROFF_W-1:0]   error_offset;
      logic                  last_result;
   } result_type;

   // Up to two results written into the queue in the same cycle, first one first.
   typedef struct packed {
      logic [1:0]  count;
      result_type  first;
      result_type  second;
   } push_type;

endpackage

[rtl/rps_result_queue.sv]
// ----------------------------------------------------------------------------
// Route pattern segmenter result queue
// Small register queue that takes up to two results a cycle from the parser
// and hands one result a cycle to the response channel while it is not stalled.
// ----------------------------------------------------------------------------
module rps_result_queue
   import rps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  push_type    push,
   input  logic        rsp_stall,
   output logic        head_valid,
   output result_type  head,
   output logic        room
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   result_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                pop;

   // The head is shown whenever the queue holds anything.
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign pop        = head_valid && !rsp_stall;

   // Room for a full pair of results, counted without this cycle's pop.
   assign room = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage; the second result lands in the entry after the first.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

   // A push never overfills the queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |->
         (int'(count_ff) + int'(push.count) - int'(pop)) <= QUEUE_DEPTH)
      else $error("result queue overflow");

   // The fill count follows pushes and pops exactly.
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |=> count_ff ==
         CNT_W'($past(count_ff) + CNT_W'($past(push.count)) - CNT_W'($past(pop))))
      else $error("result queue count mismatch");

   // The queue comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> count_ff == '0 && !head_valid)
      else $error("result queue not empty after reset");

endmodule

[rtl/route_pattern_segmenter.sv]
// ----------------------------------------------------------------------------
// Route pattern segmenter
// Splits a route pattern, one byte per request, into slash-separated
// segments and reports each segment followed by a closing status.
// ----------------------------------------------------------------------------
// A request carries one pattern byte, an end flag and a no-byte flag; it is
// captured in an input register and parsed combinationally, and the resulting
// segment descriptor and, on the end request, the status are written into a
// four-entry result queue that drives the response channel. A request is
// taken every cycle as long as the queue has room for two results, so the
// sustained rate is one request per cycle, limited only by the response side
// draining one result per cycle (an end request that also closes a segment
// gives two results). After a status the run state returns to its reset
// values; the user must write max_length through the csr channel only while
// the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module route_pattern_segmenter
   import rps_pkg::*;
#(
   parameter int MAX_URI_BYTES = MAX_URI_BYTES_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_pattern_byte,
   input  logic                  req_end_of_pattern,
   input  logic                  req_no_byte,
   // Response channel.
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_result_kind,
   output logic [TYPE_W-1:0]     rsp_segment_type,
   output logic [OFF_W-1:0]      rsp_segment_offset,
   output logic [LEN_W-1:0]      rsp_segment_length,
   output logic [OFF_W-1:0]      rsp_name_offset,
   output logic [NLEN_W-1:0]     rsp_name_length,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [ERROFF_W-1:0]   rsp_error_offset,
   output logic                  rsp_last_result,
   // Configuration channel.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CFG_W-1:0]      csr_max_length
);

   // Largest limit in force, and the position width that holds it plus one.
   localparam int CFG_MAX = (1 << CFG_W) - 1;
   localparam int LIM_MAX = (MAX_URI_BYTES < CFG_MAX) ? MAX_URI_BYTES : CFG_MAX;
   localparam int POS_W   = $clog2(LIM_MAX + 2);

   // Parser modes.
   localparam logic [2:0] MODE_LEAD   = 3'd0;
   localparam logic [2:0] MODE_SEG    = 3'd1;
   localparam logic [2:0] MODE_STATIC = 3'd2;
   localparam logic [2:0] MODE_PARAM  = 3'd3;
   localparam logic [2:0] MODE_AFTER  = 3'd4;
   localparam logic [2:0] MODE_ERR    = 3'd5;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_LONG     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNCLOSED = 2'd2;

   // Segment types and result kinds.
   localparam logic [TYPE_W-1:0] SEG_STATIC   = 2'd0;
   localparam logic [TYPE_W-1:0] SEG_PARAM    = 2'd1;
   localparam logic [TYPE_W-1:0] SEG_OPTIONAL = 2'd2;
   localparam logic [TYPE_W-1:0] SEG_WILDCARD = 2'd3;
   localparam logic              KIND_SEGMENT = 1'b0;
   localparam logic              KIND_STATUS  = 1'b1;

   // Pattern characters.
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_OPEN  = 8'h7B;
   localparam logic [7:0] CH_CLOSE = 8'h7D;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   // Configuration register.
   logic [CFG_W-1:0]    max_length_ff;

   // Input register.
   logic                in_valid_ff;
   logic                in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_fin_ff;
   logic                in_none_ff;

   // Run state and its next values.
   logic [2:0]          mode_ff,     mode_in;
   logic [POS_W-1:0]    pos_ff,      pos_in;
   logic [POS_W-1:0]    seg_ff,      seg_in;
   logic [POS_W-1:0]    name_ff,     name_in;
   logic [23:0]         recent_ff,   recent_in;
   logic [STATUS_W-1:0] err_ff,      err_in;
   logic [POS_W-1:0]    eoff_ff,     eoff_in;

   // Parser results and queue handshake.
   logic [POS_W-1:0]    lim;
   logic                seg_hit;
   result_type          seg_res;
   result_type          stat_res;
   push_type            push;
   logic                room;
   logic                advance;
   logic                head_valid;
   result_type          head;
   logic [POS_W-1:0]    nlen;
   logic [TYPE_W-1:0]   ptype;

   // The configuration register takes every write.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         max_length_ff <= csr_max_length;
      end
   end

   // The held request is parsed once the queue can take two results.
   assign advance   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;

   always_comb begin
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_pattern_byte;
         in_fin_ff  <= req_end_of_pattern;
         in_none_ff <= req_no_byte;
      end
   end

   // Length limit in force: the smaller of the register and the build limit.
   always_comb begin
      if (int'(max_length_ff) > MAX_URI_BYTES) begin
         lim = POS_W'(MAX_URI_BYTES);
      end else begin
         lim = POS_W'(max_length_ff);
      end
   end

   // One parse step: byte handling, then segment close and status on end.
   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      seg_in    = seg_ff;
      name_in   = name_ff;
      recent_in = recent_ff;
      err_in    = err_ff;
      eoff_in   = eoff_ff;
      seg_hit   = 1'b0;
      seg_res   = '0;
      stat_res  = '0;
      push      = '0;
      nlen      = pos_ff - name_ff;
      ptype     = SEG_PARAM;

      // Marker on a closed parameter name.
      if (nlen != '0 && recent_ff[7:0] == CH_QUEST) begin
         ptype = SEG_OPTIONAL;
         nlen  = nlen - POS_W'(1);
      end else if (nlen != '0 && recent_ff[7:0] == CH_STAR) begin
         ptype = SEG_WILDCARD;
         nlen  = nlen - POS_W'(1);
      end else if (nlen > POS_W'(3) && recent_ff[7:0] == CH_DOT &&
                   recent_ff[15:8] == CH_DOT && recent_ff[23:16] == CH_DOT) begin
         ptype = SEG_WILDCARD;
         nlen  = nlen - POS_W'(3);
      end

      if (!in_none_ff) begin
         if (pos_ff >= lim) begin
            // Too long: overrides any earlier error, position saturates.
            err_in  = ST_LONG;
            mode_in = MODE_ERR;
            pos_in  = lim + POS_W'(1);
         end else begin
            pos_in = pos_ff + POS_W'(1);
            unique case (mode_ff)
               MODE_LEAD, MODE_AFTER, MODE_SEG: begin
                  if (in_byte_ff == CH_SLASH && mode_ff != MODE_SEG) begin
                     mode_in = MODE_SEG;
                  end else if (in_byte_ff == CH_SLASH) begin
                     // A slash at the start of a segment is an empty segment.
                     seg_hit                = 1'b1;
                     seg_res.segment_offset = OFF_W'(pos_ff);
                     mode_in                = MODE_SEG;
                  end else if (in_byte_ff == CH_OPEN) begin
                     seg_in  = pos_ff;
                     name_in = pos_ff + POS_W'(1);
                     mode_in = MODE_PARAM;
                  end else begin
                     seg_in  = pos_ff;
                     mode_in = MODE_STATIC;
                  end
               end
               MODE_STATIC: begin
                  if (in_byte_ff == CH_SLASH) begin
                     seg_hit                = 1'b1;
                     seg_res.segment_offset = OFF_W'(seg_ff);
                     seg_res.segment_length = LEN_W'(pos_ff - seg_ff);
                     mode_in                = MODE_SEG;
                  end
               end
               MODE_PARAM: begin
                  if (in_byte_ff == CH_SLASH) begin
                     err_in  = ST_UNCLOSED;
                     eoff_in = name_ff;
                     mode_in = MODE_ERR;
                  end else if (in_byte_ff == CH_CLOSE) begin
                     seg_hit                = 1'b1;
                     seg_res.segment_type   = ptype;
                     seg_res.segment_offset = OFF_W'(seg_ff);
                     seg_res.segment_length = LEN_W'(pos_ff + POS_W'(1) - seg_ff);
                     seg_res.name_offset    = OFF_W'(name_ff);
                     seg_res.name_length    = NLEN_W'(nlen);
                     mode_in                = MODE_AFTER;
                  end
               end
               default: begin
                  // Error mode: bytes are only counted.
               end
            endcase
         end
         recent_in = {recent_ff[15:0], in_byte_ff};
      end

      if (in_fin_ff) begin
         // Close an open static segment or flag an open parameter.
         if (mode_in == MODE_STATIC) begin
            seg_hit                = 1'b1;
            seg_res.segment_offset = OFF_W'(seg_in);
            seg_res.segment_length = LEN_W'(pos_in - seg_in);
         end else if (mode_in == MODE_PARAM) begin
            err_in  = ST_UNCLOSED;
            eoff_in = name_in;
         end
         stat_res.result_kind = KIND_STATUS;
         stat_res.status      = err_in;
         stat_res.last_result = 1'b1;
         if (err_in == ST_UNCLOSED) begin
            stat_res.error_offset = ERROFF_W'(eoff_in);
         end
         // The next pattern starts from a clean state.
         mode_in   = MODE_LEAD;
         pos_in    = '0;
         seg_in    = '0;
         name_in   = '0;
         recent_in = '0;
         err_in    = ST_OK;
         eoff_in   = '0;
      end

      seg_res.result_kind = KIND_SEGMENT;

      // Pack the results in order into the queue push.
      if (seg_hit) begin
         push.first  = seg_res;
         push.second = stat_res;
         push.count  = in_fin_ff ? 2'd2 : 2'd1;
      end else begin
         push.first  = stat_res;
         push.count  = in_fin_ff ? 2'd1 : 2'd0;
      end
      if (!advance) begin
         push.count = 2'd0;
      end
   end

   // Run state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_LEAD;
         pos_ff    <= '0;
         seg_ff    <= '0;
         name_ff   <= '0;
         recent_ff <= '0;
         err_ff    <= ST_OK;
         eoff_ff   <= '0;
      end else if (advance) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         seg_ff    <= seg_in;
         name_ff   <= name_in;
         recent_ff <= recent_in;
         err_ff    <= err_in;
         eoff_ff   <= eoff_in;
      end
   end

   // Result queue between the parser and the response channel.
   rps_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .rsp_stall  (rsp_stall),
      .head_valid (head_valid),
      .head       (head),
      .room       (room)
   );

   assign rsp_valid          = head_valid;
   assign rsp_result_kind    = head.result_kind;
   assign rsp_segment_type   = head.segment_type;
   assign rsp_segment_offset = head.segment_offset;
   assign rsp_segment_length = head.segment_length;
   assign rsp_name_offset    = head.name_offset;
   assign rsp_name_length    = head.name_length;
   assign rsp_status         = head.status;
   assign rsp_error_offset   = head.error_offset;
   assign rsp_last_result    = head.last_result;

   // A request in the input register is held until the queue has room.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !room |=> in_valid_ff && $stable(in_byte_ff) &&
         $stable(in_fin_ff) && $stable(in_none_ff))
      else $error("held request lost");

   // The position never passes the limit plus one.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $stable(max_length_ff) |-> pos_ff <= lim + POS_W'(1))
      else $error("byte position beyond saturation");

   // A status result always clears the run state.
   a_status_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_fin_ff |=> mode_ff == MODE_LEAD && pos_ff == '0 &&
         err_ff == ST_OK)
      else $error("run state not cleared after status");

endmodule

[tb/rps_check_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Route pattern segmenter checker
// Byte codes, result codes and a scoreboard that follows the parse of every
// accepted request and checks each response against the oldest prediction.
// ----------------------------------------------------------------------------
package rps_check_pkg;
   import rps_pkg::*;

   // Pattern bytes with a meaning to the parser.
   localparam logic [7:0] CH_SLASH    = 8'h2F;
   localparam logic [7:0] CH_OPEN     = 8'h7B;
   localparam logic [7:0] CH_CLOSE    = 8'h7D;
   localparam logic [7:0] CH_QUESTION = 8'h3F;
   localparam logic [7:0] CH_STAR     = 8'h2A;
   localparam logic [7:0] CH_DOT      = 8'h2E;

   typedef enum logic {KIND_SEGMENT, KIND_STATUS} result_kind_e;
   typedef enum logic [1:0] {SEG_STATIC, SEG_PARAM, SEG_OPTIONAL, SEG_WILDCARD} segment_type_e;
   typedef enum logic [1:0] {STATUS_OK, STATUS_TOO_LONG, STATUS_UNCLOSED} status_e;
   typedef enum logic [2:0] {
      PM_LEAD, PM_SEGMENT_START, PM_STATIC, PM_PARAM, PM_AFTER_PARAM, PM_ERROR
   } parse_mode_e;

   class segment_scoreboard;
      logic [CFG_W-1:0] max_length = MAX_LENGTH_RESET;
      parse_mode_e      mode = PM_LEAD;
      int unsigned      position = 0;
      int unsigned      piece_start = 0;
      int unsigned      name_start = 0;
      logic [23:0]      recent = '0;
      status_e          run_status = STATUS_OK;
      int unsigned      unclosed_at = 0;
      result_type       pending_records[$];
      int unsigned      mismatches = 0;

      // Every pattern starts from the same parse state.
      function void clear_run();
         mode        = PM_LEAD;
         position    = 0;
         piece_start = 0;
         name_start  = 0;
         recent      = '0;
         run_status  = STATUS_OK;
         unclosed_at = 0;
      endfunction

      function void set_max_length(logic [CFG_W-1:0] value);
         max_length = value;
      endfunction

      function void add_record(result_kind_e kind, segment_type_e seg_type,
                               int unsigned seg_off, int unsigned seg_len,
                               int unsigned nm_off, int unsigned nm_len,
                               status_e st, int unsigned err_off);
         result_type r;
         r.result_kind    = kind;
         r.segment_type   = seg_type;
         r.segment_offset = OFF_W'(seg_off);
         r.segment_length = LEN_W'(seg_len);
         r.name_offset    = OFF_W'(nm_off);
         r.name_length    = NLEN_W'(nm_len);
         r.status         = st;
         r.error_offset   = ERROFF_W'(err_off);
         r.last_result    = (kind == KIND_STATUS);
         pending_records.push_back(r);
      endfunction

      // First byte of a segment: an empty segment, a parameter or static text.
      function void open_piece(logic [7:0] b);
         if (b == CH_SLASH) begin
            add_record(KIND_SEGMENT, SEG_STATIC, position, 0, 0, 0, STATUS_OK, 0);
            mode = PM_SEGMENT_START;
         end else if (b == CH_OPEN) begin
            piece_start = position;
            name_start  = position + 1;
            mode        = PM_PARAM;
         end else begin
            piece_start = position;
            mode        = PM_STATIC;
         end
      endfunction

      // One byte inside the length limit, before it enters the history.
      function void parse_byte(logic [7:0] b);
         int unsigned   name_len;
         segment_type_e seg_type;
         case (mode)
            PM_LEAD, PM_AFTER_PARAM: begin
               if (b == CH_SLASH) mode = PM_SEGMENT_START;
               else open_piece(b);
            end
            PM_SEGMENT_START: open_piece(b);
            PM_STATIC: begin
               if (b == CH_SLASH) begin
                  add_record(KIND_SEGMENT, SEG_STATIC, piece_start, position - piece_start,
                             0, 0, STATUS_OK, 0);
                  mode = PM_SEGMENT_START;
               end
            end
            PM_PARAM: begin
               if (b == CH_SLASH) begin
                  run_status  = STATUS_UNCLOSED;
                  unclosed_at = name_start;
                  mode        = PM_ERROR;
               end else if (b == CH_CLOSE) begin
                  name_len = position - name_start;
                  seg_type = SEG_PARAM;
                  // A marker at the end of the name sets the kind and is cut off.
                  if (name_len > 0 && recent[7:0] == CH_QUESTION) begin
                     seg_type = SEG_OPTIONAL;
                     name_len = name_len - 1;
                  end else if (name_len > 0 && recent[7:0] == CH_STAR) begin
                     seg_type = SEG_WILDCARD;
                     name_len = name_len - 1;
                  end else if (name_len > 3 && recent == {CH_DOT, CH_DOT, CH_DOT}) begin
                     seg_type = SEG_WILDCARD;
                     name_len = name_len - 3;
                  end
                  add_record(KIND_SEGMENT, seg_type, piece_start, position + 1 - piece_start,
                             name_start, name_len, STATUS_OK, 0);
                  mode = PM_AFTER_PARAM;
               end
            end
            default: ;
         endcase
      endfunction

      // Predict the responses to one accepted request.
      function void note_request(logic [7:0] b, logic fin, logic none);
         int unsigned limit;
         int unsigned err_off;
         limit = (max_length > MAX_URI_BYTES_DEFAULT) ? MAX_URI_BYTES_DEFAULT : max_length;
         if (!none) begin
            if (position >= limit) begin
               run_status = STATUS_TOO_LONG;
               mode       = PM_ERROR;
               position   = limit + 1;
            end else begin
               if (mode != PM_ERROR) parse_byte(b);
               position++;
            end
            recent = {recent[15:0], b};
         end
         if (fin) begin
            if (mode == PM_STATIC) begin
               add_record(KIND_SEGMENT, SEG_STATIC, piece_start, position - piece_start,
                          0, 0, STATUS_OK, 0);
            end else if (mode == PM_PARAM) begin
               run_status  = STATUS_UNCLOSED;
               unclosed_at = name_start;
            end
            err_off = (run_status == STATUS_UNCLOSED) ? unclosed_at : 0;
            add_record(KIND_STATUS, SEG_STATIC, 0, 0, 0, 0, run_status, err_off);
            clear_run();
         end
      endfunction

      function string describe(result_type r);
         return $sformatf({"kind %0d type %0d seg %0d/%0d name %0d/%0d",
                           " status %0d err %0d last %0d"},
                          r.result_kind, r.segment_type, r.segment_offset, r.segment_length,
                          r.name_offset, r.name_length, r.status, r.error_offset,
                          r.last_result);
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= 50) $display("mismatch: %s", what);
      endtask

      // Compare one accepted response with the oldest prediction.
      task check_result(result_type got);
         result_type want;
         string      bad;
         if (pending_records.size() == 0) begin
            report({"response with nothing predicted: ", describe(got)});
            return;
         end
         want = pending_records.pop_front();
         bad  = "";
         if (got.result_kind !== want.result_kind) bad = {bad, " result_kind"};
         if (got.segment_type !== want.segment_type) bad = {bad, " segment_type"};
         if (got.segment_offset !== want.segment_offset) bad = {bad, " segment_offset"};
         if (got.segment_length !== want.segment_length) bad = {bad, " segment_length"};
         if (got.name_offset !== want.name_offset) bad = {bad, " name_offset"};
         if (got.name_length !== want.name_length) bad = {bad, " name_length"};
         if (got.status !== want.status) bad = {bad, " status"};
         if (got.error_offset !== want.error_offset) bad = {bad, " error_offset"};
         if (got.last_result !== want.last_result) bad = {bad, " last_result"};
         if (bad != "") begin
            report({"wrong", bad, ": got ", describe(got), " expected ", describe(want)});
         end
      endtask
   endclass

endpackage

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Route pattern segmenter testbench
// Drives directed and random route patterns through the request channel
// under several length limits, with random request gaps and response stalls,
// and checks every response against a predicted segment and status stream.
// ----------------------------------------------------------------------------
module tb;
   import rps_pkg::*;
   import rps_check_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_PAUSE = 8;
   localparam int LONG_LIMIT  = 64;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_pattern_byte = '0;
   logic                 req_end_of_pattern = 1'b0;
   logic                 req_no_byte = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_result_kind;
   logic [TYPE_W-1:0]    rsp_segment_type;
   logic [OFF_W-1:0]     rsp_segment_offset;
   logic [LEN_W-1:0]     rsp_segment_length;
   logic [OFF_W-1:0]     rsp_name_offset;
   logic [NLEN_W-1:0]    rsp_name_length;
   logic [STATUS_W-1:0]  rsp_status;
   logic [ERROFF_W-1:0]  rsp_error_offset;
   logic                 rsp_last_result;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CFG_W-1:0]     csr_max_length = MAX_LENGTH_RESET;

   bit calm = 1'b0;
   bit hold_rsp = 1'b0;

   segment_scoreboard board = new;
   result_type        seen;

   assign seen = {rsp_result_kind, rsp_segment_type, rsp_segment_offset, rsp_segment_length,
                  rsp_name_offset, rsp_name_length, rsp_status, rsp_error_offset,
                  rsp_last_result};

   route_pattern_segmenter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pattern_byte   (req_pattern_byte),
      .req_end_of_pattern (req_end_of_pattern),
      .req_no_byte        (req_no_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_segment_type   (rsp_segment_type),
      .rsp_segment_offset (rsp_segment_offset),
      .rsp_segment_length (rsp_segment_length),
      .rsp_name_offset    (rsp_name_offset),
      .rsp_name_length    (rsp_name_length),
      .rsp_status         (rsp_status),
      .rsp_error_offset   (rsp_error_offset),
      .rsp_last_result    (rsp_last_result),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_max_length     (csr_max_length)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Check every response taken at a clock edge.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) board.check_result(seen);
      end
   end

   // Response side: random stall bursts, or one long hold when asked.
   initial begin
      int unsigned stall_left;
      int unsigned free_left;
      stall_left = 0;
      free_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp   = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left > 0) begin
            stall_left--;
         end else if (free_left > 0) begin
            free_left--;
         end else if (!calm) begin
            stall_left = $urandom_range(1, 16);
            free_left  = $urandom_range(1, 48);
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // End the run when nothing is taken on any channel for too long.
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   function automatic logic [7:0] letter();
      return 8'h61 + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] text_char();
      case ($urandom_range(0, 15))
         0: return 8'($urandom_range(0, 255));
         1: return CH_DOT;
         2: return CH_QUESTION;
         3: return CH_STAR;
         default: return letter();
      endcase
   endfunction

   function automatic logic [7:0] raw_byte();
      case ($urandom_range(0, 7))
         0: return CH_SLASH;
         1: return CH_OPEN;
         2: return CH_CLOSE;
         3: return CH_DOT;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly well-formed routes with random content; some raw byte noise.
   function automatic void build_random_route(ref logic [7:0] route[$]);
      int unsigned pieces;
      route.delete();
      if ($urandom_range(0, 6) == 0) begin
         repeat ($urandom_range(0, 12)) route.push_back(raw_byte());
         return;
      end
      if ($urandom_range(0, 1) == 1) route.push_back(CH_SLASH);
      pieces = $urandom_range(1, 5);
      for (int i = 0; i < pieces; i++) begin
         if (i != 0) begin
            case ($urandom_range(0, 9))
               0: ;
               1: begin
                  route.push_back(CH_SLASH);
                  route.push_back(CH_SLASH);
               end
               default: route.push_back(CH_SLASH);
            endcase
         end
         if ($urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(0, 6)) route.push_back(text_char());
         end else begin
            route.push_back(CH_OPEN);
            repeat ($urandom_range(0, 5)) route.push_back(text_char());
            case ($urandom_range(0, 5))
               1: route.push_back(CH_QUESTION);
               2: route.push_back(CH_STAR);
               3: repeat (3) route.push_back(CH_DOT);
               4: route.push_back(CH_DOT);
               default: ;
            endcase
            if ($urandom_range(0, 11) != 0) route.push_back(CH_CLOSE);
         end
      end
      if ($urandom_range(0, 4) == 0) route.push_back(CH_SLASH);
   endfunction

   // One request; valid stays high into the next request unless a gap is taken.
   task automatic send_item(input logic [7:0] value, input logic fin, input logic none,
                            input int unsigned idle_pct);
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_pattern_byte   <= value;
      req_end_of_pattern <= fin;
      req_no_byte        <= none;
      do @(posedge clock); while (req_stall);
      board.note_request(value, fin, none);
   endtask

   // A whole pattern, with ignored no-byte requests scattered in between.
   task automatic send_route(input logic [7:0] route[$], input bit separate_end,
                             input int unsigned idle_pct);
      for (int i = 0; i < route.size(); i++) begin
         if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b1, idle_pct);
         send_item(route[i], !separate_end && (i == route.size() - 1), 1'b0, idle_pct);
      end
      if (separate_end || route.size() == 0) send_item(8'($urandom), 1'b1, 1'b1, idle_pct);
   endtask

   task automatic send_text(input string text, input bit separate_end);
      logic [7:0] route[$];
      for (int i = 0; i < text.len(); i++) route.push_back(text[i]);
      send_route(route, separate_end, 0);
   endtask

   task automatic send_random_routes(input int unsigned count);
      logic [7:0]  route[$];
      int unsigned idle_pct;
      repeat (count) begin
         case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 5;
            default: idle_pct = 25;
         endcase
         build_random_route(route);
         send_route(route, $urandom_range(0, 3) == 0, idle_pct);
      end
   endtask

   // Let all predicted responses arrive and the pipeline settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending_records.size() != 0) @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic write_max_length(input logic [CFG_W-1:0] value);
      wait_drained();
      csr_valid      <= 1'b1;
      csr_max_length <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_max_length(value);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [7:0] route[$];
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed patterns under the reset limit.
      send_text("", 1'b1);
      send_text("//x", 1'b0);
      send_text("{a?}{b*}", 1'b1);
      send_text("{....}", 1'b0);
      send_text("{c/", 1'b0);
      send_text("d/{e", 1'b1);

      // Longest parameter a short limit allows, then a pattern running past it.
      write_max_length(CFG_W'(LONG_LIMIT));
      route.delete();
      route.push_back(CH_OPEN);
      repeat (LONG_LIMIT - 2) route.push_back(letter());
      route.push_back(CH_CLOSE);
      send_route(route, 1'b0, 5);
      route.delete();
      repeat (LONG_LIMIT - 2) route.push_back(letter());
      route.push_back(CH_SLASH);
      route.push_back(CH_OPEN);
      repeat (8) route.push_back(letter());
      send_route(route, 1'b1, 5);

      // Smallest limits.
      write_max_length('0);
      send_text("ab", 1'b0);
      send_text("", 1'b1);
      send_random_routes(6);
      write_max_length(CFG_W'(1));
      send_text("/x", 1'b0);
      send_random_routes(6);

      // Largest register value, with one long hold on the response side.
      write_max_length('1);
      send_random_routes(12);
      hold_rsp = 1'b1;
      route.delete();
      repeat (40) route.push_back(CH_SLASH);
      send_route(route, 1'b0, 0);
      send_random_routes(12);

      // Short limits that cut patterns off partway.
      repeat (4) begin
         write_max_length(CFG_W'($urandom_range(2, 40)));
         send_random_routes(6);
      end

      // Final stretch at the default limit without any idling.
      write_max_length(MAX_LENGTH_RESET);
      calm = 1'b1;
      send_random_routes(15);
      wait_drained();

      if (board.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
